@@ rtl/aorf_pkg.sv @@
// Package for the angle outlier reject filter.
// Holds the request codes, register indexes, angle constants, the result struct
// and the residue table used by the angle wrap logic. It depends on nothing.
`default_nettype none

package aorf_pkg;

  // Angle format: 1/16 degree units.
  localparam int ANGLE_W    = 16;
  localparam int THRESH_W   = 8;
  localparam int HALF_TURN  = 2880;
  localparam int FULL_TURN  = 5760;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = THRESH_W;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVIATION = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRUST     = 1'b1;

  // Request kinds carried with each input item.
  typedef enum logic [1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_CAPTURE = 2'd1,
    REQ_RELEASE = 2'd2
  } req_t;

  // State after one request has been applied.
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      referenced;
  } aorf_result_t;

  // Residue of (hi * 64) floor-mod 45 for a 5-bit signed hi.
  // 5760 = 45 * 128, so this reduces the upper digit of the wrapped value.
  function automatic logic [5:0] hi_residue(input logic [4:0] hi);
    logic [5:0] res;
    unique case (hi)
      5'd0:  res = 6'd0;
      5'd1:  res = 6'd19;
      5'd2:  res = 6'd38;
      5'd3:  res = 6'd12;
      5'd4:  res = 6'd31;
      5'd5:  res = 6'd5;
      5'd6:  res = 6'd24;
      5'd7:  res = 6'd43;
      5'd8:  res = 6'd17;
      5'd9:  res = 6'd36;
      5'd10: res = 6'd10;
      5'd11: res = 6'd29;
      5'd12: res = 6'd3;
      5'd13: res = 6'd22;
      5'd14: res = 6'd41;
      5'd15: res = 6'd15;
      5'd16: res = 6'd11;
      5'd17: res = 6'd30;
      5'd18: res = 6'd4;
      5'd19: res = 6'd23;
      5'd20: res = 6'd42;
      5'd21: res = 6'd16;
      5'd22: res = 6'd35;
      5'd23: res = 6'd9;
      5'd24: res = 6'd28;
      5'd25: res = 6'd2;
      5'd26: res = 6'd21;
      5'd27: res = 6'd40;
      5'd28: res = 6'd14;
      5'd29: res = 6'd33;
      5'd30: res = 6'd7;
      5'd31: res = 6'd26;
      default: res = 6'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/aorf_wrap.sv @@
// Relative angle logic for the angle outlier reject filter.
// Computes ((angle - reference + 2880) floor-mod 5760) - 2880 without a divider.
// Depends on aorf_pkg.
`default_nettype none

module aorf_wrap
  import aorf_pkg::*;
(
  input  wire logic signed [ANGLE_W-1:0] angle,
  input  wire logic signed [ANGLE_W-1:0] base_angle,
  output logic signed [ANGLE_W-1:0]      rel_angle
);

  logic signed [ANGLE_W+1:0] offset;
  logic [4:0]                hi;
  logic [5:0]                lo;
  logic [6:0]                digit_sum;
  logic [5:0]                digit_mod;
  logic [12:0]               turn_pos;

  always_comb begin
    // Shifted difference needs two extra bits to hold its full range.
    offset = {{2{angle[ANGLE_W-1]}}, angle} - {{2{base_angle[ANGLE_W-1]}}, base_angle}
             + (ANGLE_W+2)'(HALF_TURN);

    // offset = (hi * 64 + lo) * 128 + low7, and 5760 = 45 * 128.
    hi = offset[ANGLE_W+1:13];
    lo = offset[12:7];

    // Reduce hi * 64 + lo modulo 45; the sum stays below three times 45.
    digit_sum = {1'b0, hi_residue(hi)} + {1'b0, lo};
    if (digit_sum >= 7'd90) begin
      digit_mod = 6'(digit_sum - 7'd90);
    end else if (digit_sum >= 7'd45) begin
      digit_mod = 6'(digit_sum - 7'd45);
    end else begin
      digit_mod = digit_sum[5:0];
    end

    // Position within the turn, 0 to 5759, then recentered.
    turn_pos  = {digit_mod, offset[6:0]};
    rel_angle = signed'({3'b000, turn_pos} - ANGLE_W'(HALF_TURN));
  end

endmodule

`default_nettype wire

@@ rtl/aorf_state.sv @@
// Filter state and update logic for the angle outlier reject filter.
// Holds the filtered angle, reference and deviation count; uses aorf_wrap
// and aorf_pkg.
`default_nettype none

module aorf_state
  import aorf_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic [1:0]                req,
  input  wire logic signed [ANGLE_W-1:0] angle,
  input  wire logic [THRESH_W-1:0]       dev_thresh,
  input  wire logic [THRESH_W-1:0]       trust_thresh,
  output aorf_result_t                   result_next
);

  logic signed [ANGLE_W-1:0] held_angle;
  logic signed [ANGLE_W-1:0] reference_angle;
  logic                      reference_active;
  logic [THRESH_W-1:0]       deviation_count;

  logic signed [ANGLE_W-1:0] held_angle_next;
  logic signed [ANGLE_W-1:0] reference_angle_next;
  logic                      reference_active_next;
  logic [THRESH_W-1:0]       deviation_count_next;

  logic signed [ANGLE_W-1:0] rel_angle;
  logic signed [ANGLE_W-1:0] sample;
  logic [ANGLE_W-1:0]        diff;
  logic [ANGLE_W:0]          diff_mag;
  logic [THRESH_W-1:0]       count_inc;
  logic                      near;

  aorf_wrap u_wrap (
    .angle      (angle),
    .base_angle (reference_angle),
    .rel_angle  (rel_angle)
  );

  // Sample acceptance: near samples at once, deviating ones after enough repeats.
  always_comb begin
    sample    = reference_active ? rel_angle : angle;
    diff      = held_angle - sample;
    diff_mag  = diff[ANGLE_W-1] ? ((ANGLE_W+1)'(0) - {1'b1, diff}) : {1'b0, diff};
    near      = diff_mag < {{(ANGLE_W+1-THRESH_W){1'b0}}, dev_thresh};
    count_inc = deviation_count + 1'b1;

    held_angle_next       = held_angle;
    reference_angle_next  = reference_angle;
    reference_active_next = reference_active;
    deviation_count_next  = deviation_count;

    unique case (req)
      REQ_SAMPLE: begin
        if (near || (count_inc >= trust_thresh)) begin
          held_angle_next      = sample;
          deviation_count_next = '0;
        end else begin
          deviation_count_next = count_inc;
        end
      end
      REQ_CAPTURE: begin
        reference_angle_next  = held_angle;
        reference_active_next = 1'b1;
      end
      REQ_RELEASE: begin
        reference_active_next = 1'b0;
      end
      default: begin
        // Unused request code leaves the state as it is.
      end
    endcase

    result_next.angle      = held_angle_next;
    result_next.referenced = reference_active_next;
  end

  // State registers advance once per request taken into the result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_angle       <= '0;
      reference_angle  <= '0;
      reference_active <= 1'b0;
      deviation_count  <= '0;
    end else if (step) begin
      held_angle       <= held_angle_next;
      reference_angle  <= reference_angle_next;
      reference_active <= reference_active_next;
      deviation_count  <= deviation_count_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/angle_outlier_reject_filter.sv @@
// Angle outlier reject filter.
//
// Input stream: s_tdata carries a 16-bit signed angle in 1/16 degree, s_tuser the
// request kind (sample, capture reference, release reference). Every request
// gives one result on the output stream: m_tdata is the filtered angle after the
// request, m_tuser the referenced flag.
// A sample whose wrapped distance to the filtered angle is below the deviation
// threshold replaces it at once; otherwise the sample replaces it once the count
// of deviating samples reaches the trust threshold. While a reference is held,
// samples are first wrapped into +/- 180 degrees around it.
// Thresholds are written through the cfg port (index 0 deviation, 1 trust), which
// is always ready; write them only while no request is in flight.
// A request passes from the input register through the update logic into the
// result register. One request per cycle is sustained while m_tready stays high;
// the filtered angle loops back from its state register through the update logic.
// When the receiver stalls, the result register holds and the input register
// keeps taking one more request before s_tready drops.
// Reset clears thresholds, filtered angle, reference and count, and empties both
// registers.
// Depends on aorf_pkg and aorf_state.
`default_nettype none

module angle_outlier_reject_filter
  import aorf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Request stream.
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [15:0]            s_tdata,   // [15:0] angle
  input  wire logic [1:0]             s_tuser,   // [1:0] req_type
  // Result stream.
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [15:0]                 m_tdata,   // [15:0] filtered_angle
  output logic                        m_tuser,   // [0] referenced
  // Threshold writes.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [THRESH_W-1:0]       dev_thresh;
  logic [THRESH_W-1:0]       trust_thresh;

  logic                      in_valid;
  logic [1:0]                in_req;
  logic signed [ANGLE_W-1:0] in_angle;

  logic                      out_valid;
  aorf_result_t              out_result;
  aorf_result_t              result_next;

  logic                      advance;
  logic                      step;

  // Handshake: the result register frees when empty or taken.
  assign advance   = !out_valid || m_tready;
  assign step      = in_valid && advance;
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_result.angle;
  assign m_tuser  = out_result.referenced;

  // Threshold registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_thresh   <= '0;
      trust_thresh <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEVIATION: dev_thresh   <= cfg_data;
        REG_TRUST:     trust_thresh <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_req   <= s_tuser;
      in_angle <= signed'(s_tdata);
    end
  end

  aorf_state u_state (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .req          (in_req),
    .angle        (in_angle),
    .dev_thresh   (dev_thresh),
    .trust_thresh (trust_thresh),
    .result_next  (result_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (step) begin
      out_result <= result_next;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the angle outlier reject filter.
// It predicts every result from its own model of the filter state and checks the result stream.
// It depends on aorf_pkg and on the angle_outlier_reject_filter RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aorf_pkg::*;

  // The fourth request code is not defined and must leave the state alone.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int RANDOM_PHASES = 8;

  // Tracks the filter state and holds the results still due on the output.
  class angle_filter_model;
    logic [THRESH_W-1:0] dev_limit;
    logic [THRESH_W-1:0] trust_limit;
    logic signed [ANGLE_W-1:0] held;
    logic signed [ANGLE_W-1:0] anchor_angle;
    logic ref_on;
    logic [7:0] miss_count;
    aorf_result_t expected_q[$];
    int mismatches;

    function new();
      dev_limit = '0;
      trust_limit = '0;
      held = '0;
      anchor_angle = '0;
      ref_on = 1'b0;
      miss_count = '0;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [CFG_INDEX_W-1:0] idx, logic [THRESH_W-1:0] value);
      if (idx == REG_DEVIATION) begin
        dev_limit = value;
      end else if (idx == REG_TRUST) begin
        trust_limit = value;
      end
    endfunction

    // A sample replaces the held angle when it is close enough, or once enough
    // deviating samples in a row have been seen.
    function void take_sample(logic signed [ANGLE_W-1:0] raw);
      int s;
      int r;
      int mag;
      logic signed [ANGLE_W-1:0] diff;
      s = raw;
      if (ref_on) begin
        r = (s - int'(anchor_angle) + HALF_TURN) % FULL_TURN;
        if (r < 0) begin
          r += FULL_TURN;
        end
        s = r - HALF_TURN;
      end
      diff = held - ANGLE_W'(s);
      mag = (diff < 0) ? -int'(diff) : int'(diff);
      if (mag < int'(dev_limit)) begin
        held = ANGLE_W'(s);
        miss_count = '0;
      end else begin
        miss_count = miss_count + 8'd1;
        if (miss_count >= trust_limit) begin
          held = ANGLE_W'(s);
          miss_count = '0;
        end
      end
    endfunction

    function void note_request(logic [1:0] req, logic [ANGLE_W-1:0] angle);
      aorf_result_t res;
      case (req)
        REQ_SAMPLE: take_sample(angle);
        REQ_CAPTURE: begin
          anchor_angle = held;
          ref_on = 1'b1;
        end
        REQ_RELEASE: ref_on = 1'b0;
        default: ;
      endcase
      res.angle = held;
      res.referenced = ref_on;
      expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [ANGLE_W-1:0] angle, logic referenced);
      aorf_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (angle !== want.angle) begin
        report_mismatch($sformatf("filtered_angle %0d, expected %0d",
                                  $signed(angle), want.angle));
      end
      if (referenced !== want.referenced) begin
        report_mismatch($sformatf("referenced %0b, expected %0b",
                                  referenced, want.referenced));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit pauses_on = 1'b1;
  angle_filter_model filt = new();

  angle_outlier_reject_filter DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: check each accepted result, then pick the next ready value.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      filt.check_result(m_tdata, m_tuser);
    end
    if (pauses_on && $urandom_range(0, 99) < 25) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Presents one request, with an optional random gap first, and waits for it to be taken.
  task automatic send_request(logic [1:0] req, logic [ANGLE_W-1:0] angle);
    while (pauses_on && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= angle;
    do @(posedge clk); while (!s_tready);
    filt.note_request(req, angle);
  endtask

  // Writes both thresholds back to back; only called while the filter is idle.
  task automatic write_thresholds(logic [THRESH_W-1:0] dev, logic [THRESH_W-1:0] trust);
    logic [THRESH_W-1:0] value;
    for (int i = 0; i < 2; i++) begin
      value = (i == 0) ? dev : trust;
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? REG_DEVIATION : REG_TRUST;
      cfg_data <= value;
      do @(posedge clk); while (!cfg_ready);
      filt.set_threshold((i == 0) ? REG_DEVIATION : REG_TRUST, value);
    end
    cfg_valid <= 1'b0;
  endtask

  // Lets every outstanding result come back, plus the pipeline depth.
  task automatic settle_filter();
    s_tvalid <= 1'b0;
    while (filt.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Half the samples fall near the held angle, so both the close and the deviating paths get exercised.
  function automatic logic [ANGLE_W-1:0] pick_angle();
    int base;
    base = filt.ref_on ? int'(filt.anchor_angle) + int'(filt.held) : int'(filt.held);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return ANGLE_W'(base + int'($urandom_range(0, 600)) - 300);
      5, 6, 7: return ANGLE_W'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return ANGLE_W'(base + HALF_TURN);
          4: return ANGLE_W'(base - HALF_TURN);
          default: return ANGLE_W'(base + FULL_TURN);
        endcase
      end
    endcase
  endfunction

  function automatic logic [1:0] pick_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return REQ_SAMPLE;
    if (roll < 88) return REQ_CAPTURE;
    if (roll < 95) return REQ_RELEASE;
    return REQ_UNUSED;
  endfunction

  initial begin
    logic [THRESH_W-1:0] dev;
    logic [THRESH_W-1:0] trust;
    logic [1:0] req;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset thresholds: zero trust threshold, so every sample is taken at once.
    send_request(REQ_SAMPLE, 16'sd32767);
    send_request(REQ_SAMPLE, -16'sd32768);
    send_request(REQ_SAMPLE, 16'd0);
    send_request(REQ_UNUSED, 16'hffff);
    send_request(REQ_CAPTURE, 16'd0);
    send_request(REQ_SAMPLE, 16'sd5000);
    send_request(REQ_SAMPLE, -16'sd5000);
    send_request(REQ_SAMPLE, 16'h8000);
    send_request(REQ_RELEASE, 16'd0);
    send_request(REQ_SAMPLE, 16'sd100);
    settle_filter();

    // Widest thresholds on the deviation side; a half-range jump has the largest
    // magnitude and must count as deviating until the trust count is reached.
    write_thresholds(8'd255, 8'd3);
    send_request(REQ_SAMPLE, 16'sd100);
    repeat (3) send_request(REQ_SAMPLE, -16'sd32668);
    send_request(REQ_UNUSED, 16'h5a5a);
    send_request(REQ_CAPTURE, 16'h7fff);
    send_request(REQ_SAMPLE, 16'sd200);
    send_request(REQ_SAMPLE, 16'sd3000);
    send_request(REQ_RELEASE, 16'h8000);
    send_request(REQ_SAMPLE, 16'd0);
    settle_filter();

    // A zero deviation threshold never accepts directly.
    write_thresholds(8'd0, 8'd1);
    send_request(REQ_SAMPLE, 16'sd1);
    send_request(REQ_SAMPLE, 16'sd1);
    send_request(REQ_SAMPLE, -16'sd1);
    settle_filter();

    // Random phases, each with its own threshold pair; one phase runs without pauses.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin dev = 8'd255; trust = 8'd0; end
        1: begin
          dev = THRESH_W'($urandom_range(0, 64));
          trust = THRESH_W'($urandom_range(1, 6));
        end
        2: begin dev = 8'd0; trust = 8'd2; end
        3: begin
          dev = THRESH_W'($urandom_range(0, 255));
          trust = THRESH_W'($urandom_range(0, 8));
        end
        4: begin dev = 8'd255; trust = 8'd255; end
        5: begin
          dev = THRESH_W'($urandom_range(16, 200));
          trust = THRESH_W'($urandom_range(2, 12));
        end
        6: begin
          dev = THRESH_W'($urandom_range(0, 255));
          trust = THRESH_W'($urandom_range(0, 255));
        end
        default: begin dev = THRESH_W'($urandom_range(0, 32)); trust = 8'd3; end
      endcase
      pauses_on = (ph != 3);
      write_thresholds(dev, trust);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req = pick_request();
        send_request(req, (req == REQ_SAMPLE) ? pick_angle() : ANGLE_W'($urandom));
      end
      settle_filter();
    end

    repeat (10) @(posedge clk);
    if (filt.expected_q.size() != 0) begin
      filt.report_mismatch("results still outstanding at the end");
    end
    if (filt.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ angle_outlier_reject_filter.f @@
rtl/aorf_pkg.sv
rtl/aorf_wrap.sv
rtl/aorf_state.sv
rtl/angle_outlier_reject_filter.sv
verif/tb_top.sv
